/* rtl/mmcs_pkg.sv */
package mmcs_pkg;

    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] adjusted_pixel;
        logic       flat;
    } out_item_t;

    typedef enum logic {
        MODE_MEASURE = 1'b0,
        MODE_ADJUST  = 1'b1
    } mode_t;

    // adjust pixel with the min/max in force when it arrived
    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] lowest;
        logic [7:0] highest;
        logic       relatch;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } back_state_t;

endpackage

/* rtl/min_max_contrast_stretch.sv */
// channel   direction  handshake             payload
// item      in         push / full           mode, pixel, frame_start
// result    out        pop / empty           adjusted_pixel, flat
//
// Measure items update min and max and give no result. An adjust item goes
// through the queue and output register; items are taken while the queue is not
// full. The first adjust item after any measure item, if its span exceeds one,
// waits in the back end while a scale division runs one quotient bit per cycle.
// full follows the front-to-back queue; empty follows the output register.
// Reset is asynchronous, active low, and leaves min 255, max 0, scale unlatched.
module min_max_contrast_stretch #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mmcs_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output mmcs_pkg::out_item_t result
);
    import mmcs_pkg::*;

    q_entry_t  q_data;
    q_entry_t  q_head;
    q_status_t q_status;
    logic      q_wr;
    logic      q_rd;

    mmcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .q_status (q_status),
        .full     (full),
        .q_wr     (q_wr),
        .q_data   (q_data)
    );

    mmcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_data),
        .rd      (q_rd),
        .head    (q_head),
        .status  (q_status)
    );

    mmcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_status (q_status),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

/* rtl/mmcs_fifo.sv */
module mmcs_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  mmcs_pkg::q_entry_t wr_data,
    input  logic              rd,
    output mmcs_pkg::q_entry_t head,
    output mmcs_pkg::q_status_t status
);
    import mmcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr && !status.full;
    assign do_rd = rd && !status.empty;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/mmcs_front.sv */
module mmcs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mmcs_pkg::in_item_t  item,
    input  mmcs_pkg::q_status_t q_status,
    output logic               full,
    output logic               q_wr,
    output mmcs_pkg::q_entry_t  q_data
);
    import mmcs_pkg::*;

    logic [7:0] lowest_reg, lowest_next;
    logic [7:0] highest_reg, highest_next;
    logic       pending_reg, pending_next;
    logic       take;

    assign full = q_status.full;
    assign take = push && !q_status.full;
    assign q_wr = take && (item.mode == MODE_ADJUST);

    assign q_data.pixel   = item.pixel;
    assign q_data.lowest  = lowest_reg;
    assign q_data.highest = highest_reg;
    assign q_data.relatch = pending_reg;

    always_comb
    begin
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        pending_next = pending_reg;
        if (take)
        begin
            if (item.mode == MODE_MEASURE)
            begin
                pending_next = 1'b1;
                if (item.frame_start)
                begin
                    lowest_next  = item.pixel;
                    highest_next = item.pixel;
                end
                else
                begin
                    if (item.pixel < lowest_reg)
                    begin
                        lowest_next = item.pixel;
                    end
                    if (item.pixel > highest_reg)
                    begin
                        highest_next = item.pixel;
                    end
                end
            end
            else
            begin
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= PIX_MAX;
            highest_reg <= '0;
            pending_reg <= 1'b1;
        end
        else
        begin
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            pending_reg <= pending_next;
        end
    end

endmodule

/* rtl/mmcs_back.sv */
module mmcs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mmcs_pkg::q_entry_t  head,
    input  mmcs_pkg::q_status_t q_status,
    output logic               q_rd,
    input  logic               pop,
    output logic               empty,
    output mmcs_pkg::out_item_t result
);
    import mmcs_pkg::*;

    back_state_t state_reg, state_next;
    logic        done_reg, done_next;
    logic [7:0]  const_reg, const_next;
    logic [2:0]  shift_reg, shift_next;
    logic [7:0]  d_reg, d_next;
    logic [7:0]  num_reg, num_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  quo_reg, quo_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic [7:0]  span;
    logic [7:0]  span_m1;
    logic [2:0]  sh;
    logic [15:0] num;
    logic [7:0]  half;
    logic        need_div;
    logic        can_emit;
    logic [8:0]  trial;
    logic        ge;
    logic [7:0]  diff;
    logic [15:0] prod;
    logic [15:0] shifted;
    out_item_t   res;

    assign span    = (head.highest > head.lowest) ? head.highest - head.lowest : 8'd0;
    assign span_m1 = span - 8'd1;

    always_comb
    begin
        sh = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (span_m1[i])
            begin
                sh = 3'(i);
            end
        end
    end

    // 255 * half
    assign half = 8'd1 << sh;
    assign num  = {half, 8'd0} - {8'd0, half};

    assign need_div = head.relatch && !done_reg && (span >= 8'd2);
    assign can_emit = (state_reg == ST_IDLE) && !q_status.empty && !need_div
                      && (!out_valid_reg || pop);
    assign q_rd     = can_emit;

    assign trial = {rem_reg, num_reg[cnt_reg]};
    assign ge    = (trial >= {1'b0, d_reg});

    assign diff    = head.pixel - head.lowest;
    assign prod    = diff * const_reg;
    assign shifted = prod >> shift_reg;

    always_comb
    begin
        res.flat = 1'b0;
        if (span == 8'd0)
        begin
            res.adjusted_pixel = '0;
            res.flat           = 1'b1;
        end
        else if (span == 8'd1)
        begin
            res.adjusted_pixel = (head.pixel > head.lowest) ? PIX_MAX : 8'd0;
        end
        else
        begin
            res.adjusted_pixel = shifted[7:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        const_next     = const_reg;
        shift_next     = shift_reg;
        d_next         = d_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty && need_div)
                begin
                    state_next = ST_DIV;
                    shift_next = sh;
                    d_next     = span;
                    num_next   = num[7:0];
                    rem_next   = {1'b0, num[14:8]};
                    quo_next   = '0;
                    cnt_next   = 3'd7;
                end
                else if (can_emit)
                begin
                    if (head.relatch && !done_reg)
                    begin
                        const_next = '0;
                        shift_next = '0;
                    end
                    out_valid_next = 1'b1;
                    out_next       = res;
                    done_next      = 1'b0;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? 8'(trial - {1'b0, d_reg}) : trial[7:0];
                quo_next = {quo_reg[6:0], ge};
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    const_next = {quo_reg[6:0], ge};
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            const_reg     <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            const_reg     <= const_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_div_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !q_status.empty)
        else $error("division running with no entry waiting");

    a_no_emit_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> (state_reg == ST_IDLE))
        else $error("entry drained during division");

    a_const_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == 3'd0) |=> (const_reg != PIX_MAX))
        else $error("scale constant out of range");

    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.flat) |-> (out_reg.adjusted_pixel == 8'd0))
        else $error("flat result not zero");

endmodule
